// ===== rtl/core/obsd_pkg.sv =====
// Shared types and constants for the oriented box signed distance block.
// Used by every module under rtl/core; depends on nothing.
package obsd_pkg;

  localparam int AXES      = 3;
  localparam int CRD_W     = 16;
  localparam int D_W       = CRD_W + 1;
  localparam int PROD_W    = CRD_W + D_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int FRAC_SH   = 14;
  localparam int R_W       = ACC_W - FRAC_SH;
  localparam int MAG_W     = R_W - 1;
  localparam int PEN_W     = R_W + 1;
  localparam int ESQ_W     = 2 * MAG_W;
  localparam int SUM_W     = ESQ_W + 2;
  localparam int SQ_STEPS  = SUM_W / 2;
  localparam int ROOT_W    = SQ_STEPS;
  localparam int REM_W     = ROOT_W + 2;
  localparam int SD_W      = 18;
  localparam int CFG_W     = 3 * CRD_W;
  localparam int IDX_W     = 3;
  localparam int NST       = 6 + SQ_STEPS + 1;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (FRAC_SH - 1));
  localparam logic [ROOT_W:0] SD_MAX = (ROOT_W + 1)'((1 << (SD_W - 1)) - 1);

  typedef enum logic [IDX_W-1:0] {
    REG_CENTER = 3'd0,
    REG_HALF   = 3'd1,
    REG_ROT0   = 3'd2,
    REG_ROT1   = 3'd3,
    REG_ROT2   = 3'd4
  } cfg_reg_t;

  typedef logic [3:0] lane_en_t;

endpackage

// ===== rtl/core/obsd_lane.sv =====
// One axis lane: rotates the offset into the box frame, clamps to the half
// extent and squares the residual. Depends on obsd_pkg.
module obsd_lane (
  input  logic                                   clk,
  input  obsd_pkg::lane_en_t                     en,
  input  logic [obsd_pkg::AXES-1:0][obsd_pkg::D_W-1:0]   d,
  input  logic [obsd_pkg::AXES-1:0][obsd_pkg::CRD_W-1:0] col,
  input  logic [obsd_pkg::CRD_W-1:0]             half,
  output logic signed [obsd_pkg::PEN_W-1:0]      pen,
  output logic [obsd_pkg::ESQ_W-1:0]             esq
);

  logic signed [obsd_pkg::PROD_W-1:0] prod_r [obsd_pkg::AXES];
  logic signed [obsd_pkg::ACC_W-1:0]  acc;
  logic signed [obsd_pkg::ACC_W-1:0]  acc_rnd;
  logic signed [obsd_pkg::R_W-1:0]    r_r;
  logic signed [obsd_pkg::R_W-1:0]    r_neg;
  logic [obsd_pkg::MAG_W-1:0]         mag;
  logic signed [obsd_pkg::PEN_W-1:0]  pen_nxt;
  logic signed [obsd_pkg::PEN_W-1:0]  pen3_r;
  logic signed [obsd_pkg::PEN_W-1:0]  pen4_r;
  logic [obsd_pkg::MAG_W-1:0]         e_nxt;
  logic [obsd_pkg::MAG_W-1:0]         e_r;
  logic [obsd_pkg::ESQ_W-1:0]         esq_r;

  always_ff @(posedge clk) begin
    for (int j = 0; j < obsd_pkg::AXES; j++) begin
      if (en[0]) begin
        prod_r[j] <= $signed(col[j]) * $signed(d[j]);
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int j = 0; j < obsd_pkg::AXES; j++) begin
      acc = acc + obsd_pkg::ACC_W'(prod_r[j]);
    end
    acc_rnd = acc + obsd_pkg::ROUND_HALF;
  end

  always_comb begin
    r_neg   = -r_r;
    mag     = r_r[obsd_pkg::R_W-1] ? r_neg[obsd_pkg::MAG_W-1:0] : r_r[obsd_pkg::MAG_W-1:0];
    pen_nxt = $signed({2'b00, mag}) - $signed({(obsd_pkg::PEN_W - obsd_pkg::CRD_W)'(0), half});
    e_nxt   = (pen_nxt > 0) ? pen_nxt[obsd_pkg::MAG_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      r_r <= acc_rnd[obsd_pkg::ACC_W-1:obsd_pkg::FRAC_SH];
    end
    if (en[2]) begin
      pen3_r <= pen_nxt;
      e_r    <= e_nxt;
    end
    if (en[3]) begin
      pen4_r <= pen3_r;
      esq_r  <= e_r * e_r;
    end
  end

  assign pen = pen4_r;
  assign esq = esq_r;

endmodule

// ===== rtl/core/obsd_sqrt.sv =====
// Pipelined integer square root, two radicand bits per stage, with remainder.
// Depends on obsd_pkg.
module obsd_sqrt (
  input  logic                              clk,
  input  logic [obsd_pkg::SQ_STEPS-1:0]     en,
  input  logic [obsd_pkg::SUM_W-1:0]        s_in,
  output logic [obsd_pkg::ROOT_W-1:0]       root,
  output logic [obsd_pkg::REM_W-1:0]        rem
);

  logic [obsd_pkg::SUM_W-1:0]  s_r   [obsd_pkg::SQ_STEPS];
  logic [obsd_pkg::ROOT_W-1:0] q_r   [obsd_pkg::SQ_STEPS];
  logic [obsd_pkg::REM_W-1:0]  rem_r [obsd_pkg::SQ_STEPS];

  for (genvar t = 0; t < obsd_pkg::SQ_STEPS; t++) begin : g_step
    logic [obsd_pkg::SUM_W-1:0]  s_prev;
    logic [obsd_pkg::ROOT_W-1:0] q_prev;
    logic [obsd_pkg::REM_W-1:0]  rem_prev;
    logic [obsd_pkg::REM_W-1:0]  rem_sh;
    logic [obsd_pkg::REM_W-1:0]  trial;

    if (t == 0) begin : g_first
      assign s_prev   = s_in;
      assign q_prev   = '0;
      assign rem_prev = '0;
    end else begin : g_next
      assign s_prev   = s_r[t-1];
      assign q_prev   = q_r[t-1];
      assign rem_prev = rem_r[t-1];
    end

    assign rem_sh = {rem_prev[obsd_pkg::REM_W-3:0],
                     s_prev[2*(obsd_pkg::SQ_STEPS-1-t)+1 -: 2]};
    assign trial  = {q_prev, 2'b01};

    always_ff @(posedge clk) begin
      if (en[t]) begin
        s_r[t] <= s_prev;
        if (rem_sh >= trial) begin
          rem_r[t] <= rem_sh - trial;
          q_r[t]   <= {q_prev[obsd_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_r[t] <= rem_sh;
          q_r[t]   <= {q_prev[obsd_pkg::ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root = q_r[obsd_pkg::SQ_STEPS-1];
  assign rem  = rem_r[obsd_pkg::SQ_STEPS-1];

endmodule

// ===== rtl/core/oriented_box_signed_distance.sv =====
// Top level of the oriented box signed distance block: configuration
// registers, axis lanes, merge stage, root pipeline and output register.
// Depends on obsd_pkg, obsd_lane and obsd_sqrt.
//
// Usage: a query point enters on the in_ stream as one word (x, y, z, each
// signed Q5.10). One result word leaves on the out_ stream: the signed
// distance in Q7.10 in tdata and the inside flag in tuser.
// The pipeline is 28 stages deep; one point is taken every cycle when
// nothing stalls.
// The depth is the offset stage, four lane stages for rotation and clamp,
// one merge stage, 21 root stages with one result bit each and the output.
// Each stage moves forward when it is empty or the stage after it moves,
// so bubbles close up and in_tready stays high while any stage is free,
// also while a finished word waits on out_tready low.
// Reset (rst_n low, synchronous) empties the pipeline and loads the box
// registers with a zero center, zero extents and the identity rotation.
// The user writes configuration words through cfg_we, cfg_addr and cfg_wdata
// while the block is idle, which it does not check; unknown indexes are ignored.
module oriented_box_signed_distance (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [47:0]                      in_tdata,   // point_x, point_y, point_z
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [23:0]                      out_tdata,  // signed_distance, zero pad
  output logic                             out_tuser,  // is_inside
  input  logic                             cfg_we,
  input  logic [obsd_pkg::IDX_W-1:0]       cfg_addr,
  input  logic [obsd_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int ST_MERGE = 5;
  localparam int ST_OUT   = obsd_pkg::NST - 1;

  logic [obsd_pkg::CFG_W-1:0] center_r, half_r, rot0_r, rot1_r, rot2_r;
  logic [obsd_pkg::CFG_W-1:0] rows [3];
  logic [obsd_pkg::NST-1:0]   v_r;
  logic [obsd_pkg::NST-1:0]   en;
  logic                       in_acc;

  logic [obsd_pkg::AXES-1:0][obsd_pkg::D_W-1:0] d_r;
  logic signed [obsd_pkg::PEN_W-1:0] pen  [obsd_pkg::AXES];
  logic [obsd_pkg::ESQ_W-1:0]        esq  [obsd_pkg::AXES];

  logic [obsd_pkg::SUM_W-1:0]        sum_nxt, sum_r;
  logic signed [obsd_pkg::PEN_W-1:0] best_nxt;
  logic                              ins_nxt;
  logic signed [obsd_pkg::PEN_W-1:0] best_pipe_r [obsd_pkg::SQ_STEPS+1];
  logic                              ins_pipe_r  [obsd_pkg::SQ_STEPS+1];
  logic [obsd_pkg::ROOT_W-1:0]       root;
  logic [obsd_pkg::REM_W-1:0]        rem;
  logic [obsd_pkg::ROOT_W:0]         q_rnd;
  logic [obsd_pkg::SD_W-1:0]         sd_nxt, sd_r;
  logic                              ins_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r <= '0;
      half_r   <= '0;
      rot0_r   <= obsd_pkg::CFG_W'(1 << 14);
      rot1_r   <= obsd_pkg::CFG_W'(1) << 30;
      rot2_r   <= obsd_pkg::CFG_W'(1) << 46;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        obsd_pkg::REG_CENTER: center_r <= cfg_wdata;
        obsd_pkg::REG_HALF:   half_r   <= cfg_wdata;
        obsd_pkg::REG_ROT0:   rot0_r   <= cfg_wdata;
        obsd_pkg::REG_ROT1:   rot1_r   <= cfg_wdata;
        obsd_pkg::REG_ROT2:   rot2_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign rows[0] = rot0_r;
  assign rows[1] = rot1_r;
  assign rows[2] = rot2_r;

  always_comb begin
    en[obsd_pkg::NST-1] = !v_r[obsd_pkg::NST-1] || out_tready;
    for (int k = obsd_pkg::NST - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_tready = en[0];
  assign in_acc    = in_tvalid && en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < obsd_pkg::NST; k++) begin
        if (en[k]) begin
          v_r[k] <= (k == 0) ? in_acc : v_r[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int j = 0; j < obsd_pkg::AXES; j++) begin
        d_r[j] <= obsd_pkg::D_W'($signed(in_tdata[16*j +: 16]))
                - obsd_pkg::D_W'($signed(center_r[16*j +: 16]));
      end
    end
  end

  for (genvar i = 0; i < obsd_pkg::AXES; i++) begin : g_lane
    logic [obsd_pkg::AXES-1:0][obsd_pkg::CRD_W-1:0] col;
    for (genvar j = 0; j < obsd_pkg::AXES; j++) begin : g_col
      assign col[j] = rows[j][16*i +: 16];
    end
    obsd_lane u_lane (
      .clk  (clk),
      .en   (en[4:1]),
      .d    (d_r),
      .col  (col),
      .half (half_r[16*i +: 16]),
      .pen  (pen[i]),
      .esq  (esq[i])
    );
  end

  always_comb begin
    sum_nxt  = '0;
    best_nxt = pen[0];
    ins_nxt  = 1'b1;
    for (int i = 0; i < obsd_pkg::AXES; i++) begin
      sum_nxt = sum_nxt + obsd_pkg::SUM_W'(esq[i]);
      if (pen[i] > best_nxt) begin
        best_nxt = pen[i];
      end
      if (pen[i] >= 0) begin
        ins_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_MERGE]) begin
      sum_r          <= sum_nxt;
      best_pipe_r[0] <= best_nxt;
      ins_pipe_r[0]  <= ins_nxt;
    end
    for (int t = 1; t <= obsd_pkg::SQ_STEPS; t++) begin
      if (en[ST_MERGE+t]) begin
        best_pipe_r[t] <= best_pipe_r[t-1];
        ins_pipe_r[t]  <= ins_pipe_r[t-1];
      end
    end
  end

  obsd_sqrt u_sqrt (
    .clk  (clk),
    .en   (en[ST_MERGE+obsd_pkg::SQ_STEPS:ST_MERGE+1]),
    .s_in (sum_r),
    .root (root),
    .rem  (rem)
  );

  always_comb begin
    q_rnd = {1'b0, root} + ((rem > obsd_pkg::REM_W'(root)) ? 1'b1 : 1'b0);
    if (ins_pipe_r[obsd_pkg::SQ_STEPS]) begin
      sd_nxt = best_pipe_r[obsd_pkg::SQ_STEPS][obsd_pkg::SD_W-1:0];
    end else if (q_rnd > obsd_pkg::SD_MAX) begin
      sd_nxt = obsd_pkg::SD_MAX[obsd_pkg::SD_W-1:0];
    end else begin
      sd_nxt = q_rnd[obsd_pkg::SD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      sd_r      <= sd_nxt;
      ins_out_r <= ins_pipe_r[obsd_pkg::SQ_STEPS];
    end
  end

  assign out_tvalid = v_r[ST_OUT];
  assign out_tdata  = {(24 - obsd_pkg::SD_W)'(0), sd_r};
  assign out_tuser  = ins_out_r;

  a_inside_negative: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> sd_r[obsd_pkg::SD_W-1])
    else $error("inside result is not negative");

  a_outside_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> !sd_r[obsd_pkg::SD_W-1])
    else $error("outside result is negative");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("pipeline refuses input with empty output stage");

  a_reset_empty: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !out_tvalid)
    else $error("output valid right after reset");

endmodule
